/* hw/rtl/dsm_pkg.sv */
// Shared types and constants of the deduplicating update stack.
package dsm_pkg;

    localparam int DSM_STACK_DEPTH = 256;
    localparam int DSM_HASH_SLOTS  = 512;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_MERGE = 2'd1,
        ACT_POP   = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] distance;
        logic [7:0]  level;
        logic [31:0] stamp;
        logic [63:0] handle;
    } entry_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic eval;
        logic push;
        logic pop;
        logic merge;
    } cell_ctl_t;

endpackage

/* hw/rtl/dsm_if.sv */
// Request and response channel interfaces of the update stack.
interface dsm_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        dist_value;
    logic [7:0]         level_value;
    logic [31:0]        stamp;
    logic [63:0]        chunk_handle;

    modport source (output valid, action, pos_x, pos_y, dist_value, level_value, stamp,
                    chunk_handle, input ready);
    modport sink (input valid, action, pos_x, pos_y, dist_value, level_value, stamp,
                  chunk_handle, output ready);
endinterface

interface dsm_rsp_if;
    logic               valid;
    logic               ready;
    logic               added;
    logic               merged;
    logic               found;
    logic               rejected_full;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [15:0]        out_distance;
    logic [7:0]         out_level;
    logic [31:0]        out_stamp;
    logic [63:0]        out_handle;

    modport source (output valid, added, merged, found, rejected_full, out_x, out_y,
                    out_distance, out_level, out_stamp, out_handle, input ready);
    modport sink (input valid, added, merged, found, rejected_full, out_x, out_y,
                  out_distance, out_level, out_stamp, out_handle, output ready);
endinterface

/* hw/rtl/dsm_cell.sv */
// One stack cell: holds an entry, shifts with its neighbors, matches keys locally.
module dsm_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dsm_pkg::cell_ctl_t  ctl,
    input  logic [CNT_W-1:0]    count,
    input  dsm_pkg::entry_t     upd,
    input  dsm_pkg::entry_t     upper,
    input  dsm_pkg::entry_t     lower,
    output dsm_pkg::entry_t     data,
    output logic                match,
    output logic                merge_ok
);
    import dsm_pkg::*;

    entry_t data_reg;
    logic   match_reg;
    logic   mok_reg;
    logic   live;
    logic   refuse;

    assign live   = count > CNT_W'(IDX);
    assign refuse = (upd.level < data_reg.level) ||
                    ((upd.stamp == data_reg.stamp) && (upd.distance >= data_reg.distance));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            mok_reg   <= 1'b0;
        end
        else if (ctl.eval)
        begin
            match_reg <= live && (data_reg.x == upd.x) && (data_reg.y == upd.y);
            mok_reg   <= !refuse;
        end
    end

    // Keys are unique in the stack, so at most one cell takes a merge.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
            data_reg <= upper;
        else if (ctl.pop)
            data_reg <= lower;
        else if (ctl.merge && match_reg && mok_reg)
            data_reg <= upd;
    end

    assign data     = data_reg;
    assign match    = match_reg;
    assign merge_ok = mok_reg;

endmodule

/* hw/rtl/dedup_stack_with_hash_merge.sv */
// Top level of the deduplicating update stack built as a chain of shifting cells.
//
//  channel | modport | transfer carries
//  req     | sink    | action, key, distance, level, stamp, handle
//  rsp     | source  | flags and popped entry
//
// Each item passes through the steps accept, parallel key match in every cell, then decide and update.
// The cell chain shifts down on a push and up on a pop, so the top is always cell 0.
// One item is in work at a time; req.ready is low until it is decided.
// The decide step waits while a previous response has not been transferred.
// Reset clears the count and the control; stored entries need no clearing.
module dedup_stack_with_hash_merge #(
    parameter int STACK_DEPTH = dsm_pkg::DSM_STACK_DEPTH,
    parameter int HASH_SLOTS  = dsm_pkg::DSM_HASH_SLOTS
) (
    input  logic      clk,
    input  logic      rst_n,
    dsm_req_if.sink   req,
    dsm_rsp_if.source rsp
);
    import dsm_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    // Hash and stack always hold the same keys, so the hash fills with the stack.
    localparam int CAP   = (HASH_SLOTS < STACK_DEPTH) ? HASH_SLOTS : STACK_DEPTH;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_MATCH  = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    action_t          act_reg;
    entry_t           item_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovalid_reg, ovalid_next;
    logic [3:0]       flags_reg, flags_next;
    entry_t           odata_reg, odata_next;

    cell_ctl_t        ctl;
    entry_t           cell_data [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] match_vec;
    logic [STACK_DEPTH-1:0] mok_vec;
    logic             hit, mhit, go, full, do_push, do_pop;

    assign req.ready = (state_reg == ST_IDLE);
    assign hit  = |match_vec;
    assign mhit = |(match_vec & mok_vec);
    assign full = count_reg >= CNT_W'(CAP);
    assign go   = (state_reg == ST_DECIDE) && (!ovalid_reg || rsp.ready);

    assign do_push = go && !hit && !full &&
                     ((act_reg == ACT_PUSH) || (act_reg == ACT_MERGE));
    assign do_pop  = go && (act_reg == ACT_POP) && (count_reg != '0);

    always_comb
    begin
        ctl.eval  = (state_reg == ST_MATCH);
        ctl.push  = do_push;
        ctl.pop   = do_pop;
        ctl.merge = go && (act_reg == ACT_MERGE) && hit;
    end

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            entry_t up_d, lo_d;
            if (gi == 0)
            begin : g_top
                assign up_d = item_reg;
            end
            else
            begin : g_mid
                assign up_d = cell_data[gi-1];
            end
            if (gi == STACK_DEPTH - 1)
            begin : g_bot
                assign lo_d = cell_data[gi];
            end
            else
            begin : g_low
                assign lo_d = cell_data[gi+1];
            end
            dsm_cell #(.IDX(gi), .CNT_W(CNT_W)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .count    (count_reg),
                .upd      (item_reg),
                .upper    (up_d),
                .lower    (lo_d),
                .data     (cell_data[gi]),
                .match    (match_vec[gi]),
                .merge_ok (mok_vec[gi])
            );
        end
    endgenerate

    // flags: {added, merged, found, rejected_full}
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        flags_next  = flags_reg;
        odata_next  = odata_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = ST_MATCH;
            end
            ST_MATCH:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (go)
                begin
                    state_next  = ST_IDLE;
                    ovalid_next = 1'b1;
                    flags_next  = '0;
                    odata_next  = '0;
                    case (act_reg)
                        ACT_PUSH, ACT_MERGE:
                        begin
                            if (!hit)
                            begin
                                flags_next[3] = !full;
                                flags_next[0] = full;
                            end
                            else if (act_reg == ACT_MERGE)
                                flags_next[2] = mhit;
                            if (do_push)
                                count_next = count_reg + 1'b1;
                        end
                        ACT_POP:
                        begin
                            if (do_pop)
                            begin
                                flags_next[1] = 1'b1;
                                odata_next    = cell_data[0];
                                count_next    = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            flags_next[1] = hit;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg <= flags_next;
        odata_reg <= odata_next;
        if (req.valid && req.ready)
        begin
            act_reg           <= action_t'(req.action);
            item_reg.x        <= req.pos_x;
            item_reg.y        <= req.pos_y;
            item_reg.distance <= req.dist_value;
            item_reg.level    <= req.level_value;
            item_reg.stamp    <= req.stamp;
            item_reg.handle   <= req.chunk_handle;
        end
    end

    assign rsp.valid         = ovalid_reg;
    assign rsp.added         = flags_reg[3];
    assign rsp.merged        = flags_reg[2];
    assign rsp.found         = flags_reg[1];
    assign rsp.rejected_full = flags_reg[0];
    assign rsp.out_x         = $signed(odata_reg.x);
    assign rsp.out_y         = $signed(odata_reg.y);
    assign rsp.out_distance  = odata_reg.distance;
    assign rsp.out_level     = odata_reg.level;
    assign rsp.out_stamp     = odata_reg.stamp;
    assign rsp.out_handle    = odata_reg.handle;

endmodule

/* hw/rtl/dsm_checker.sv */
// Port-level checks of the update stack, bound to its top level.
module dsm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        added,
    input logic        merged,
    input logic        found,
    input logic        rejected_full,
    input logic [31:0] out_x,
    input logic [63:0] out_handle
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transfer");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while one is in work");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot0({added, merged, found, rejected_full}))
        else $error("more than one result flag set");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !found |-> (out_x == 32'd0) && (out_handle == 64'd0))
        else $error("entry fields not zero without a found entry");

endmodule

bind dedup_stack_with_hash_merge dsm_checker u_dsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .added         (rsp.added),
    .merged        (rsp.merged),
    .found         (rsp.found),
    .rejected_full (rsp.rejected_full),
    .out_x         (rsp.out_x),
    .out_handle    (rsp.out_handle)
);

/* tb/dsm_checker.sv */
// Transfer monitor, stack and hash predictor, and response comparator for the update stack.
`timescale 1ns / 100ps

module dsm_scoreboard
    import dsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dsm_req_if   req,
    dsm_rsp_if   rsp,
    output int   errors,
    output int   waiting,
    output int   n_added,
    output int   n_merged,
    output int   n_rejected,
    output int   n_popped
);

    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_USED  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    typedef struct packed {
        logic   added;
        logic   merged;
        logic   found;
        logic   rejected_full;
        entry_t ent;
    } outcome_t;

    entry_t      stack_mem [DSM_STACK_DEPTH];
    int unsigned depth_now;
    logic [31:0] key_x [DSM_HASH_SLOTS];
    logic [31:0] key_y [DSM_HASH_SLOTS];
    logic [1:0]  mark  [DSM_HASH_SLOTS];
    outcome_t    due_q [$];
    int          pend;

    assign waiting = pend;

    function automatic logic [31:0] scramble(logic [31:0] v);
        v = v ^ (v >> 16);
        v = v * 32'h7feb352d;
        v = v ^ (v >> 15);
        v = v * 32'h846ca68b;
        v = v ^ (v >> 16);
        return v;
    endfunction

    function automatic int unsigned home_of(logic [31:0] x, logic [31:0] y);
        logic [31:0] ym;
        ym = scramble(y) * 32'h9e3779b9;
        return (scramble(x) ^ ym) % DSM_HASH_SLOTS;
    endfunction

    function automatic bit lookup(logic [31:0] x, logic [31:0] y, output int unsigned at);
        int unsigned i;
        i = home_of(x, y);
        at = 0;
        for (int n = 0; n < DSM_HASH_SLOTS; n++)
        begin
            if (mark[i] == SLOT_EMPTY)
                return 0;
            if (mark[i] == SLOT_USED && key_x[i] == x && key_y[i] == y)
            begin
                at = i;
                return 1;
            end
            i = (i + 1 >= DSM_HASH_SLOTS) ? 0 : i + 1;
        end
        return 0;
    endfunction

    function automatic bit free_slot(logic [31:0] x, logic [31:0] y, output int unsigned at);
        int unsigned i;
        i = home_of(x, y);
        at = 0;
        for (int n = 0; n < DSM_HASH_SLOTS; n++)
        begin
            if (mark[i] != SLOT_USED)
            begin
                at = i;
                return 1;
            end
            i = (i + 1 >= DSM_HASH_SLOTS) ? 0 : i + 1;
        end
        return 0;
    endfunction

    // Returns 1 when added, 2 when rejected, 0 when the key was already waiting.
    function automatic int insert_update(entry_t e);
        int unsigned s;
        if (lookup(e.x, e.y, s))
            return 0;
        if (depth_now >= DSM_STACK_DEPTH)
            return 2;
        if (!free_slot(e.x, e.y, s))
            return 2;
        stack_mem[depth_now] = e;
        depth_now++;
        key_x[s] = e.x;
        key_y[s] = e.y;
        mark[s]  = SLOT_USED;
        return 1;
    endfunction

    function automatic outcome_t apply_request(action_t act, entry_t e);
        outcome_t    o;
        int unsigned s;
        int unsigned k;
        int          r;
        o = '0;
        case (act)
            ACT_PUSH:
            begin
                r = insert_update(e);
                o.added = (r == 1);
                o.rejected_full = (r == 2);
            end
            ACT_MERGE:
            begin
                if (lookup(e.x, e.y, s))
                begin
                    for (k = 0; k < depth_now; k++)
                        if (stack_mem[k].x == e.x && stack_mem[k].y == e.y)
                            break;
                    if (k < depth_now &&
                        !(e.level < stack_mem[k].level ||
                          (e.stamp == stack_mem[k].stamp &&
                           e.distance >= stack_mem[k].distance)))
                    begin
                        stack_mem[k] = e;
                        o.merged = 1'b1;
                    end
                end
                else
                begin
                    r = insert_update(e);
                    o.added = (r == 1);
                    o.rejected_full = (r == 2);
                end
            end
            ACT_POP:
            begin
                if (depth_now > 0)
                begin
                    depth_now--;
                    o.found = 1'b1;
                    o.ent = stack_mem[depth_now];
                    if (lookup(o.ent.x, o.ent.y, s))
                        mark[s] = SLOT_TOMB;
                end
            end
            default:
                o.found = lookup(e.x, e.y, s);
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t got;
        entry_t   e;
        if (!rst_n)
        begin
            depth_now = 0;
            for (int i = 0; i < DSM_HASH_SLOTS; i++)
                mark[i] = SLOT_EMPTY;
            due_q.delete();
            pend = 0;
            errors = 0;
            n_added = 0;
            n_merged = 0;
            n_rejected = 0;
            n_popped = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                e = '{x: req.pos_x, y: req.pos_y, distance: req.dist_value,
                      level: req.level_value, stamp: req.stamp, handle: req.chunk_handle};
                want = apply_request(action_t'(req.action), e);
                n_added += want.added;
                n_merged += want.merged;
                n_rejected += want.rejected_full;
                n_popped += (action_t'(req.action) == ACT_POP && want.found);
                due_q.push_back(want);
            end
            if (rsp.valid && rsp.ready)
            begin
                got = '{added: rsp.added, merged: rsp.merged, found: rsp.found,
                        rejected_full: rsp.rejected_full,
                        ent: '{x: rsp.out_x, y: rsp.out_y, distance: rsp.out_distance,
                               level: rsp.out_level, stamp: rsp.out_stamp,
                               handle: rsp.out_handle}};
                if (due_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: response transfer with nothing outstanding: %h", got);
                end
                else
                begin
                    want = due_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"ERROR: response mismatch\n  exp add=%0b mrg=%0b fnd=%0b",
                                      " rej=%0b x=%h y=%h d=%h l=%h s=%h h=%h\n",
                                      "  got add=%0b mrg=%0b fnd=%0b rej=%0b x=%h y=%h d=%h",
                                      " l=%h s=%h h=%h"},
                                     want.added, want.merged, want.found, want.rejected_full,
                                     want.ent.x, want.ent.y, want.ent.distance, want.ent.level,
                                     want.ent.stamp, want.ent.handle,
                                     got.added, got.merged, got.found, got.rejected_full,
                                     got.ent.x, got.ent.y, got.ent.distance, got.ent.level,
                                     got.ent.stamp, got.ent.handle);
                    end
                end
            end
            pend = due_q.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// Stimulus, clock, reset and verdict for the deduplicating update stack.
`timescale 1ns / 100ps

module tb_top;
    import dsm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic clk;
    logic rst_n;
    int   cycles;
    int   errors;
    int   waiting;
    int   n_added;
    int   n_merged;
    int   n_rejected;
    int   n_popped;
    int   n_sent;
    bit   calm_tx;
    bit   calm_rx;

    logic [31:0] key_pool [16];

    dsm_req_if req ();
    dsm_rsp_if rsp ();

    dedup_stack_with_hash_merge uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    dsm_scoreboard chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .errors     (errors),
        .waiting    (waiting),
        .n_added    (n_added),
        .n_merged   (n_merged),
        .n_rejected (n_rejected),
        .n_popped   (n_popped)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one request; the inter-request gap is drawn here.
    task automatic send(action_t act, logic [31:0] x, logic [31:0] y, logic [15:0] d,
                        logic [7:0] lv, logic [31:0] st, logic [63:0] h);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.action       <= act;
        req.pos_x        <= x;
        req.pos_y        <= y;
        req.dist_value   <= d;
        req.level_value  <= lv;
        req.stamp        <= st;
        req.chunk_handle <= h;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic send_random(int push_pct, int merge_pct, int pop_pct);
        int          r;
        action_t     act;
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] d;
        logic [7:0]  lv;
        logic [31:0] st;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            act = ACT_PUSH;
        else if (r < push_pct + merge_pct)
            act = ACT_MERGE;
        else if (r < push_pct + merge_pct + pop_pct)
            act = ACT_POP;
        else
            act = ACT_QUERY;
        // A small key pool makes duplicates, merges and tombstone reuse common.
        if ($urandom_range(0, 9) < 7)
        begin
            x = key_pool[$urandom_range(0, 15)];
            y = key_pool[$urandom_range(0, 15)];
        end
        else
        begin
            x = $urandom;
            y = $urandom;
        end
        d  = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        lv = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        st = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 2)) : $urandom;
        send(act, x, y, d, lv, st, {$urandom, $urandom});
    endtask

    // Response side: a fresh stall for every result, with calm stretches.
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                calm_rx = !calm_rx;
            stall = calm_rx ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int drain;
        cycles = 0;
        n_sent = 0;
        calm_tx = 1'b0;
        calm_rx = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.action = ACT_PUSH;
        req.pos_x = '0;
        req.pos_y = '0;
        req.dist_value = '0;
        req.level_value = '0;
        req.stamp = '0;
        req.chunk_handle = '0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'hffff_ffff;
        key_pool[3] = 32'h0000_0000;
        for (int i = 4; i < 16; i++)
            key_pool[i] = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, duplicates, both merge refusals, empty pop.
        send(ACT_POP, 0, 0, 0, 0, 0, 0);
        send(ACT_PUSH, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 8'hff, 32'hffff_ffff, '1);
        send(ACT_PUSH, 32'h8000_0000, 32'h8000_0000, 16'h0000, 8'h00, 32'h0, '0);
        send(ACT_PUSH, 32'h8000_0000, 32'h8000_0000, 16'h1234, 8'h01, 32'h5, 64'h5);
        send(ACT_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0);
        send(ACT_QUERY, 32'h0, 32'hffff_ffff, 0, 0, 0, 0);
        send(ACT_MERGE, 32'h8000_0000, 32'h8000_0000, 16'h0010, 8'h05, 32'h7, 64'ha5a5);
        send(ACT_MERGE, 32'h8000_0000, 32'h8000_0000, 16'h0001, 8'h04, 32'h9, 64'hbad);
        send(ACT_MERGE, 32'h8000_0000, 32'h8000_0000, 16'h0010, 8'h05, 32'h7, 64'hbad);
        send(ACT_MERGE, 32'h8000_0000, 32'h8000_0000, 16'h0020, 8'h05, 32'h7, 64'hbad);
        send(ACT_MERGE, 32'h8000_0000, 32'h8000_0000, 16'h000f, 8'h05, 32'h7, 64'hc0de);
        send(ACT_MERGE, 32'h0, 32'hffff_ffff, 16'h5555, 8'haa, 32'haaaa_5555, 64'h3c3c);
        send(ACT_POP, 0, 0, 0, 0, 0, 0);
        send(ACT_QUERY, 32'h0, 32'hffff_ffff, 0, 0, 0, 0);
        send(ACT_POP, 0, 0, 0, 0, 0, 0);
        send(ACT_POP, 0, 0, 0, 0, 0, 0);
        send(ACT_POP, 0, 0, 0, 0, 0, 0);
        send(ACT_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0);

        // Fill the store past its depth so that full rejections appear.
        for (int i = 0; i < 262; i++)
            send(ACT_PUSH, $urandom, $urandom, 16'($urandom), 8'($urandom), $urandom,
                 {$urandom, $urandom});
        send(ACT_MERGE, $urandom, $urandom, 0, 0, 0, 0);
        req.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);

        // Random phases, repeated in turn: push-heavy, balanced, then pop-heavy to drain and hit empty.
        for (int i = 0; i < 1470; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                calm_tx = !calm_tx;
            case ((i / 250) % 3)
                0: send_random(35, 35, 10);
                1: send_random(25, 25, 25);
                default: send_random(10, 15, 60);
            endcase
        end
        req.valid <= 1'b0;
        @(posedge clk);

        while (waiting != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 40)
        begin
            @(posedge clk);
            drain++;
        end

        $display("Sent %0d requests: %0d added, %0d merged, %0d rejected full, %0d popped",
                 n_sent, n_added, n_merged, n_rejected, n_popped);
        $display("Mismatches: %0d", errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/dsm_pkg.sv
hw/rtl/dsm_if.sv
hw/rtl/dsm_cell.sv
hw/rtl/dedup_stack_with_hash_merge.sv
hw/rtl/dsm_checker.sv
tb/dsm_checker.sv
tb/tb_top.sv
